>>> hdl/rfa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the rational fraction ALU.
package rfa_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned NUM_BITS  = 32;
  localparam int unsigned DEN_BITS  = 31;
  localparam int unsigned FUNC_BITS = 3;
  localparam int unsigned CNT_BITS  = 5;

  // Operation codes.
  localparam logic [FUNC_BITS-1:0] FUNC_ADD = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_SUB = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_MUL = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_DIV = 3'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_RED = 3'd4;

  // Inverse of 3 modulo 2**32, and the largest product that marks a multiple of 3.
  localparam logic [NUM_BITS-1:0] INV3      = 32'hAAAA_AAAB;
  localparam logic [NUM_BITS-1:0] THIRD_MAX = 32'h5555_5555;

  typedef struct packed {
    logic [FUNC_BITS-1:0]       func;
    logic signed [NUM_BITS-1:0] a_num;
    logic [DEN_BITS-1:0]        a_den;
    logic signed [NUM_BITS-1:0] b_num;
    logic [DEN_BITS-1:0]        b_den;
  } rfa_in_t;

  typedef struct packed {
    logic signed [NUM_BITS-1:0] res_num;
    logic signed [NUM_BITS-1:0] res_den;
    logic                       err;
  } rfa_out_t;

endpackage

>>> hdl/rfa_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for operand and result transfers.
interface rfa_in_if;
  logic              valid;
  logic              ready;
  rfa_pkg::rfa_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rfa_out_if;
  logic              valid;
  logic              ready;
  rfa_pkg::rfa_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/rational_fraction_alu.sv
`timescale 1ns / 1ps
// Top level of the rational fraction ALU: sequencer around one shared multiplier.
//
//   channel  direction  handshake              payload
//   in_ch    sink       valid/ready            func, a_num, a_den, b_num, b_den
//   out_ch   source     valid/ready            res_num, res_den, err
//
// Multiply and divide pass through PN, PD and PST; an error goes straight to FIN.
// Add and subtract run a binary gcd of the denominators (one shift or subtract per
// cycle), then two 31-step restoring divisions and the multiply/add steps LCM, TA, TB, SUM.
// Reduce halves once per factor 2 removed and runs RMD, RMN and RCHK per factor 3 test.
// Reset is synchronous and active low; it clears the sequencer and the result valid.
// in_ch is ready only between items; a waiting result does not block the next transfer,
// but a finished item holds in its last state until the result register is free.
module rational_fraction_alu #(
  parameter int WORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  rfa_in_if.sink           in_ch,
  rfa_out_if.source        out_ch
);
  import rfa_pkg::*;

  // Results wrap to WORD_BITS; above 32 bits the low 32 bits are all that remain.
  localparam int WrapBits = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam logic [NUM_BITS-1:0] HiMask = ~((32'd1 << WrapBits) - 32'd1);

  typedef enum logic [16:0] {
    ST_IDLE   = 17'b00000000000000001,
    ST_COMMON = 17'b00000000000000010,
    ST_GCD    = 17'b00000000000000100,
    ST_DIVA   = 17'b00000000000001000,
    ST_DIVB   = 17'b00000000000010000,
    ST_LCM    = 17'b00000000000100000,
    ST_TA     = 17'b00000000001000000,
    ST_TB     = 17'b00000000010000000,
    ST_SUM    = 17'b00000000100000000,
    ST_PN     = 17'b00000001000000000,
    ST_PD     = 17'b00000010000000000,
    ST_PST    = 17'b00000100000000000,
    ST_RED    = 17'b00001000000000000,
    ST_RMD    = 17'b00010000000000000,
    ST_RMN    = 17'b00100000000000000,
    ST_RCHK   = 17'b01000000000000000,
    ST_FIN    = 17'b10000000000000000
  } state_t;

  function automatic logic [NUM_BITS-1:0] wrap_word(input logic [NUM_BITS-1:0] x);
    return x[WrapBits-1] ? (x | HiMask) : (x & ~HiMask);
  endfunction

  state_t                state_r, state_nxt;
  logic [FUNC_BITS-1:0]  func_r, func_nxt;
  logic [NUM_BITS-1:0]   an_r, an_nxt;
  logic [DEN_BITS-1:0]   ad_r, ad_nxt;
  logic [NUM_BITS-1:0]   bn_r, bn_nxt;
  logic [DEN_BITS-1:0]   bd_r, bd_nxt;
  logic [DEN_BITS-1:0]   u_r, u_nxt;
  logic [DEN_BITS-1:0]   v_r, v_nxt;
  logic [CNT_BITS-1:0]   k_r, k_nxt;
  logic [DEN_BITS-1:0]   dvd_r, dvd_nxt;
  logic [DEN_BITS-1:0]   rem_r, rem_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [DEN_BITS-1:0]   qa_r, qa_nxt;
  logic [DEN_BITS-1:0]   qb_r, qb_nxt;
  logic [NUM_BITS-1:0]   mul_r, mul_nxt;
  logic [NUM_BITS-1:0]   acc_r, acc_nxt;
  logic [NUM_BITS-1:0]   n_r, n_nxt;
  logic [NUM_BITS-1:0]   d_r, d_nxt;
  logic                  err_r, err_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rfa_out_t              out_data_r, out_data_nxt;

  logic                  in_xfer;
  logic                  in_bad;
  logic [NUM_BITS-1:0]   mul_a, mul_b;
  logic [NUM_BITS-1:0]   mul_lo;
  logic                  gcd_ge;
  logic [DEN_BITS-1:0]   gcd_diff;
  logic [NUM_BITS-1:0]   div_sh;
  logic                  div_ge;
  logic [DEN_BITS-1:0]   div_rem;
  logic [DEN_BITS-1:0]   div_q;
  logic [NUM_BITS-1:0]   abs_n;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Operand check: bad code, zero denominator or zero divisor.
  assign in_bad = (in_ch.data.func > FUNC_RED) || (in_ch.data.a_den == '0) ||
                  ((in_ch.data.func != FUNC_RED) && (in_ch.data.b_den == '0)) ||
                  ((in_ch.data.func == FUNC_DIV) && (in_ch.data.b_num == '0));

  // Binary gcd step: subtract the smaller odd value from the larger.
  assign gcd_ge   = (u_r >= v_r);
  assign gcd_diff = gcd_ge ? (u_r - v_r) : (v_r - u_r);

  // Restoring division step by the gcd held in u_r.
  assign div_sh  = {rem_r, dvd_r[DEN_BITS-1]};
  assign div_ge  = (div_sh >= {1'b0, u_r});
  assign div_rem = div_ge ? DEN_BITS'(div_sh - {1'b0, u_r}) : div_sh[DEN_BITS-1:0];
  assign div_q   = {dvd_r[DEN_BITS-2:0], div_ge};

  assign abs_n = n_r[NUM_BITS-1] ? (~n_r + 32'd1) : n_r;

  // Shared multiplier operand selection; only the low word of a product is kept.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_LCM: begin
        mul_a = {1'b0, qa_r};
        mul_b = {1'b0, bd_r};
      end
      ST_TA: begin
        mul_a = {1'b0, qb_r};
        mul_b = an_r;
      end
      ST_TB: begin
        mul_a = {1'b0, qa_r};
        mul_b = bn_r;
      end
      ST_PN: begin
        mul_a = an_r;
        mul_b = (func_r == FUNC_MUL) ? bn_r : {1'b0, bd_r};
      end
      ST_PD: begin
        mul_a = {1'b0, ad_r};
        mul_b = (func_r == FUNC_MUL) ? {1'b0, bd_r} : bn_r;
      end
      ST_RMD: begin
        mul_a = d_r;
        mul_b = INV3;
      end
      ST_RMN: begin
        mul_a = abs_n;
        mul_b = INV3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_lo = mul_a * mul_b;

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    an_nxt        = an_r;
    ad_nxt        = ad_r;
    bn_nxt        = bn_r;
    bd_nxt        = bd_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    k_nxt         = k_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    mul_nxt       = mul_lo;
    acc_nxt       = acc_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    err_nxt       = err_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          func_nxt = in_ch.data.func;
          an_nxt   = in_ch.data.a_num;
          ad_nxt   = in_ch.data.a_den;
          bn_nxt   = in_ch.data.b_num;
          bd_nxt   = in_ch.data.b_den;
          u_nxt    = in_ch.data.a_den;
          v_nxt    = in_ch.data.b_den;
          k_nxt    = '0;
          n_nxt    = in_ch.data.a_num;
          d_nxt    = {1'b0, in_ch.data.a_den};
          err_nxt  = in_bad;
          if (in_bad) begin
            n_nxt     = '0;
            d_nxt     = '0;
            state_nxt = ST_FIN;
          end else if (in_ch.data.func == FUNC_RED) begin
            state_nxt = ST_RED;
          end else if ((in_ch.data.func == FUNC_MUL) || (in_ch.data.func == FUNC_DIV)) begin
            state_nxt = ST_PN;
          end else begin
            state_nxt = ST_COMMON;
          end
        end
      end
      // Strip the powers of two shared by both denominators.
      ST_COMMON: begin
        if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 5'd1;
        end else begin
          state_nxt = ST_GCD;
        end
      end
      ST_GCD: begin
        if (v_r == '0) begin
          u_nxt     = u_r << k_r;
          dvd_nxt   = ad_r;
          rem_nxt   = '0;
          cnt_nxt   = CNT_BITS'(DEN_BITS - 1);
          state_nxt = ST_DIVA;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else begin
          if (gcd_ge) begin
            u_nxt = v_r;
          end
          v_nxt = gcd_diff;
        end
      end
      // a_den / gcd, then b_den / gcd.
      ST_DIVA: begin
        rem_nxt = div_rem;
        dvd_nxt = div_q;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          qa_nxt    = div_q;
          dvd_nxt   = bd_r;
          rem_nxt   = '0;
          cnt_nxt   = CNT_BITS'(DEN_BITS - 1);
          state_nxt = ST_DIVB;
        end
      end
      ST_DIVB: begin
        rem_nxt = div_rem;
        dvd_nxt = div_q;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          qb_nxt    = div_q;
          state_nxt = ST_LCM;
        end
      end
      ST_LCM: begin
        state_nxt = ST_TA;
      end
      ST_TA: begin
        d_nxt     = mul_r;
        state_nxt = ST_TB;
      end
      ST_TB: begin
        acc_nxt   = mul_r;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        n_nxt     = (func_r == FUNC_ADD) ? (acc_r + mul_r) : (acc_r - mul_r);
        state_nxt = ST_FIN;
      end
      ST_PN: begin
        state_nxt = ST_PD;
      end
      ST_PD: begin
        n_nxt     = mul_r;
        state_nxt = ST_PST;
      end
      ST_PST: begin
        d_nxt     = mul_r;
        state_nxt = ST_FIN;
      end
      // Halve while both are even, else test for a common factor 3.
      ST_RED: begin
        if (!n_r[0] && !d_r[0]) begin
          n_nxt = {n_r[NUM_BITS-1], n_r[NUM_BITS-1:1]};
          d_nxt = d_r >> 1;
        end else begin
          state_nxt = ST_RMD;
        end
      end
      ST_RMD: begin
        state_nxt = ST_RMN;
      end
      ST_RMN: begin
        acc_nxt   = mul_r;
        state_nxt = ST_RCHK;
      end
      ST_RCHK: begin
        if ((acc_r <= THIRD_MAX) && (mul_r <= THIRD_MAX)) begin
          d_nxt     = acc_r;
          n_nxt     = n_r[NUM_BITS-1] ? (~mul_r + 32'd1) : mul_r;
          state_nxt = ST_RED;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      // Hand the result to the output register once it is free.
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_data_nxt.res_num = wrap_word(n_r);
          out_data_nxt.res_den = wrap_word(d_r);
          out_data_nxt.err     = err_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    an_r       <= an_nxt;
    ad_r       <= ad_nxt;
    bn_r       <= bn_nxt;
    bd_r       <= bd_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    k_r        <= k_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    qa_r       <= qa_nxt;
    qb_r       <= qb_nxt;
    mul_r      <= mul_nxt;
    acc_r      <= acc_nxt;
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  // The divisor of both divisions is a nonzero gcd.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVA || state_r == ST_DIVB) |-> (u_r != '0))
    else $error("gcd is zero during division");

  // The first division hands over to the second after its last step.
  a_div_handover: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVA && cnt_r == '0) |=> (state_r == ST_DIVB))
    else $error("first division did not hand over");

  // The denominator never reaches zero while reducing.
  a_red_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RED) |-> (d_r != '0))
    else $error("zero denominator during reduce");

  // A finished item waits while the previous result is still unread.
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ch.ready) |=>
    (state_r == ST_FIN && out_valid_r))
    else $error("result overwritten before transfer");

  // An error result carries a zero fraction.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.err) |->
    (out_ch.data.res_num == '0 && out_ch.data.res_den == '0))
    else $error("error result with nonzero fraction");

endmodule
